[rtl/rrpb_pkg.sv]
// Shared types and register indexes for the rounded rectangle pixel blender.
// No dependencies.
package rrpb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_RECT_LEFT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_TOP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_RADIUS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR    = 3'd5;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [31:0]        dst_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        covered;
    } pix_out_t;

endpackage

[rtl/rounded_rect_pixel_blender.sv]
// Rounded rectangle coverage test with ARGB8888 source-over fill blend.
// Depends on rrpb_pkg for the beat types and register indexes.
// An input beat passes through the input register and then the result register.
// Throughput: one pixel per clock while out_stall is low; the squared-distance test and channel blend sit in one stage.
// Stall on the output reaches in_stall only when both registers hold a pixel.
// Reset clears both valid flags and loads the register reset values.
module rounded_rect_pixel_blender
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rrpb_pkg::pix_in_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rrpb_pkg::pix_out_t               out_data,
    input  logic                             cfg_we,
    input  logic [rrpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rrpb_pkg::*;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    logic signed [15:0] left_reg;
    logic signed [15:0] top_reg;
    logic [14:0]        width_reg;
    logic [14:0]        height_reg;
    logic [15:0]        radius_reg;
    logic [31:0]        fill_reg;

    logic     s1_valid_reg, s1_valid_next;
    pix_in_t  s1_data_reg;
    logic     out_valid_reg, out_valid_next;
    pix_out_t out_data_reg, out_data_next;

    logic in_beat;
    logic s1_move;

    // per-axis corner center
    function automatic logic signed [17:0] centre_of(
        input logic signed [17:0] p,
        input logic signed [17:0] lo,
        input logic signed [17:0] len,
        input logic signed [17:0] r
    );
        logic signed [17:0] c;
        begin
            priority if (p < lo + r)
            begin
                c = lo + r - 18'sd1;
            end
            else if (p >= lo + len - r)
            begin
                c = lo + len - r;
            end
            else
            begin
                c = p;
            end
            return c;
        end
    endfunction

    // (s*a + d*(255-a) + 127) / 255, divide done as shift-add (exact below 65535)
    function automatic logic [7:0] mix(
        input logic [7:0] s,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic [15:0] v;
        logic [16:0] t;
        begin
            v = {8'b0, s} * {8'b0, a} + {8'b0, d} * {8'b0, ~a} + 16'd127;
            t = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
            return t[15:8];
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
            radius_reg <= '0;
            fill_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RECT_LEFT:     left_reg   <= $signed(cfg_data[15:0]);
                REG_RECT_TOP:      top_reg    <= $signed(cfg_data[15:0]);
                REG_RECT_WIDTH:    width_reg  <= cfg_data[14:0];
                REG_RECT_HEIGHT:   height_reg <= cfg_data[14:0];
                REG_CORNER_RADIUS: radius_reg <= cfg_data[15:0];
                REG_FILL_COLOR:    fill_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_beat  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_beat)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = s1_move || (out_valid_reg && out_stall);
    end

    // coverage
    logic signed [17:0] x_s, y_s, left_s, top_s, w_s, h_s, r_s;
    logic signed [17:0] dx_s, dy_s;
    logic [14:0]        side_min;
    logic [13:0]        lim;
    logic [13:0]        r;
    logic [13:0]        dx_abs, dy_abs;
    logic [27:0]        dx2, dy2, rr;
    logic [28:0]        dist2;
    logic               in_box;
    logic               covered;

    assign x_s    = 18'(s1_data_reg.pixel_x);
    assign y_s    = 18'(s1_data_reg.pixel_y);
    assign left_s = 18'(left_reg);
    assign top_s  = 18'(top_reg);
    assign w_s    = $signed({3'b000, width_reg});
    assign h_s    = $signed({3'b000, height_reg});

    assign side_min = (width_reg < height_reg) ? width_reg : height_reg;
    assign lim      = side_min[14:1];
    assign r        = (radius_reg > {2'b00, lim}) ? lim : radius_reg[13:0];
    assign r_s      = $signed({4'b0000, r});

    assign in_box = (x_s >= left_s) && (x_s < left_s + w_s) &&
                    (y_s >= top_s)  && (y_s < top_s + h_s);

    assign dx_s = x_s - centre_of(x_s, left_s, w_s, r_s);
    assign dy_s = y_s - centre_of(y_s, top_s, h_s, r_s);

    // inside the box each offset is below the radius; outside it is ignored
    assign dx_abs = dx_s[17] ? 14'(-dx_s) : dx_s[13:0];
    assign dy_abs = dy_s[17] ? 14'(-dy_s) : dy_s[13:0];

    assign dx2   = dx_abs * dx_abs;
    assign dy2   = dy_abs * dy_abs;
    assign rr    = r * r;
    assign dist2 = {1'b0, dx2} + {1'b0, dy2};

    assign covered = in_box && (dist2 <= {1'b0, rr});

    // blend
    always_comb
    begin
        out_data_next.covered   = covered;
        out_data_next.out_pixel = s1_data_reg.dst_pixel;
        if (covered)
        begin
            priority if (fill_reg[31:24] == ALPHA_OPAQUE)
            begin
                out_data_next.out_pixel = fill_reg;
            end
            else if (fill_reg[31:24] == ALPHA_CLEAR)
            begin
                out_data_next.out_pixel = s1_data_reg.dst_pixel;
            end
            else
            begin
                out_data_next.out_pixel = {
                    ALPHA_OPAQUE,
                    mix(fill_reg[23:16], s1_data_reg.dst_pixel[23:16], fill_reg[31:24]),
                    mix(fill_reg[15:8],  s1_data_reg.dst_pixel[15:8],  fill_reg[31:24]),
                    mix(fill_reg[7:0],   s1_data_reg.dst_pixel[7:0],   fill_reg[31:24])
                };
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/rrpb_checker.sv]
// Port-level checks for rounded_rect_pixel_blender, bound into that module.
// Depends on rrpb_pkg for the beat types.
module rrpb_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input rrpb_pkg::pix_in_t                in_data,
    input logic                             out_valid,
    input logic                             out_stall,
    input rrpb_pkg::pix_out_t               out_data,
    input logic                             cfg_we,
    input logic [rrpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [rrpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rrpb_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{in_data, cfg_we, cfg_index, cfg_data};

    // a held result beat keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // input side backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // an accepted pixel leads, past the input and result registers, to a valid beat at the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted pixel did not reach the output");

    // covered is never unknown on a result beat
    a_no_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data.covered))
        else $error("covered flag unknown on a result beat");

endmodule

bind rounded_rect_pixel_blender rrpb_checker u_rrpb_checker (.*);

[tb/tb_rounded_rect_pixel_blender.sv]
// Self-checking testbench for rounded_rect_pixel_blender: directed probes, then extreme and random settings.
// Depends on rrpb_pkg and the block itself; every result is predicted inside this file.
module tb_rounded_rect_pixel_blender;
    import rrpb_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 16;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 125;
    localparam int STEADY_PHASE   = 3;
    localparam int PROBES         = 22;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] top;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] radius;
        logic [31:0] fill;
    } rect_cfg_t;

    typedef struct packed {
        int unsigned setting;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] dst;
        bit          typed;
        logic [31:0] pix;
        bit          cov;
    } probe_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    pix_in_t            in_data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pix_out_t           out_data;
    logic               cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rect_cfg_t   regs_now;
    rect_cfg_t   directed_cfg [0:5];
    probe_t      probes [0:PROBES-1];
    pix_out_t    pending_shades [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          steady = 1'b0;

    rounded_rect_pixel_blender u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic longint radius_in_use();
        longint w;
        longint h;
        longint lim;
        longint r;
        w = longint'(regs_now.width[14:0]);
        h = longint'(regs_now.height[14:0]);
        lim = (w < h ? w : h) / 2;
        r = longint'(regs_now.radius[15:0]);
        return r > lim ? lim : r;
    endfunction

    function automatic longint corner_centre(longint p, longint lo, longint len, longint r);
        if (p < lo + r)
            return lo + r - 1;
        if (p >= lo + len - r)
            return lo + len - r;
        return p;
    endfunction

    function automatic bit inside_shape(longint x, longint y);
        longint l;
        longint t;
        longint w;
        longint h;
        longint r;
        longint dx;
        longint dy;
        l = longint'($signed(regs_now.left[15:0]));
        t = longint'($signed(regs_now.top[15:0]));
        w = longint'(regs_now.width[14:0]);
        h = longint'(regs_now.height[14:0]);
        if (w == 0 || h == 0)
            return 1'b0;
        if (x < l || x >= l + w || y < t || y >= t + h)
            return 1'b0;
        r = radius_in_use();
        if (r == 0)
            return 1'b1;
        dx = x - corner_centre(x, l, w, r);
        dy = y - corner_centre(y, t, h, r);
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic logic [7:0] mix_channel(int unsigned s, int unsigned d, int unsigned a);
        return 8'((s * a + d * (255 - a) + 127) / 255);
    endfunction

    function automatic pix_out_t shade_pixel(pix_in_t p);
        pix_out_t    res;
        logic [31:0] f;
        logic [31:0] d;
        f = regs_now.fill;
        d = p.dst_pixel;
        res.out_pixel = d;
        res.covered = inside_shape(longint'(p.pixel_x), longint'(p.pixel_y));
        if (res.covered)
        begin
            if (f[31:24] == 8'hFF)
                res.out_pixel = f;
            else if (f[31:24] != 8'h00)
                res.out_pixel = {8'hFF,
                                 mix_channel(f[23:16], d[23:16], f[31:24]),
                                 mix_channel(f[15:8], d[15:8], f[31:24]),
                                 mix_channel(f[7:0], d[7:0], f[31:24])};
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_coord(longint lo, longint len, longint r);
        longint span;
        longint v;
        span = r > 300 ? 300 : r;
        case ($urandom_range(0, 9))
            0, 1, 2: v = lo - 3 + $urandom_range(0, 32'(span + 6));
            3, 4, 5: v = lo + len - span - 3 + $urandom_range(0, 32'(span + 6));
            6, 7:    v = lo + $urandom_range(0, len > 0 ? 32'(len - 1) : 0);
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    function automatic pix_in_t pick_pixel();
        pix_in_t p;
        longint  r;
        r = radius_in_use();
        p.pixel_x = pick_coord(longint'($signed(regs_now.left[15:0])),
                               longint'(regs_now.width[14:0]), r);
        p.pixel_y = pick_coord(longint'($signed(regs_now.top[15:0])),
                               longint'(regs_now.height[14:0]), r);
        p.dst_pixel = $urandom;
        return p;
    endfunction

    function automatic logic [31:0] pick_length();
        logic [31:0] len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 40);
            7, 8:                len = $urandom_range(41, 2000);
            default:             len = $urandom_range(1, 32767);
        endcase
        return len | ($urandom_range(0, 1) ? ($urandom & 32'hFFFF8000) : 32'h0);
    endfunction

    function automatic logic [31:0] pick_origin();
        int v;
        v = $urandom_range(0, 1) ? $urandom_range(0, 400) - 200 : $urandom;
        return {($urandom_range(0, 1) ? 16'($urandom) : 16'h0), v[15:0]};
    endfunction

    function automatic rect_cfg_t pick_setting(int ph);
        rect_cfg_t   c;
        logic [7:0]  alpha;
        int unsigned lim;
        case ($urandom_range(0, 4))
            0:       alpha = 8'h00;
            1:       alpha = 8'hFF;
            2:       alpha = 8'h01;
            3:       alpha = 8'hFE;
            default: alpha = $urandom_range(0, 255);
        endcase
        c.fill = {alpha, 24'($urandom)};
        if (ph == 0)
        begin
            c.left = 32'h7FFF;
            c.top = 32'h7FFF;
            c.width = 32'h7FFF;
            c.height = 32'h7FFF;
            c.radius = 32'hFFFF;
        end
        else if (ph == 1)
        begin
            c.left = 32'h8000;
            c.top = 32'h8000;
            c.width = 32'h1;
            c.height = 32'h1;
            c.radius = 32'h0;
            c.fill = 32'hFFFFFFFF;
        end
        else if (ph == 2)
        begin
            c.left = 32'h8000;
            c.top = 32'h8000;
            c.width = 32'h7FFF;
            c.height = 32'h7FFF;
            c.radius = 32'h0;
        end
        else
        begin
            c.left = pick_origin();
            c.top = pick_origin();
            c.width = pick_length();
            c.height = pick_length();
            lim = (c.width[14:0] < c.height[14:0] ? c.width[14:0] : c.height[14:0]) / 2;
            case ($urandom_range(0, 9))
                0, 1:          c.radius = 32'h0;
                2, 3, 4, 5, 6: c.radius = $urandom_range(0, lim + 2);
                7, 8:          c.radius = 32'hFFFF;
                default:       c.radius = $urandom;
            endcase
        end
        return c;
    endfunction

    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_shades.size() == 0)
            begin
                mismatches++;
                $display("%0t result beat with nothing pending: expected none, actual %h/%b",
                         $time, out_data.out_pixel, out_data.covered);
            end
            else
            begin
                want = pending_shades.pop_front();
                if (out_data.out_pixel !== want.out_pixel)
                begin
                    mismatches++;
                    $display("%0t out_pixel: expected %h, actual %h",
                             $time, want.out_pixel, out_data.out_pixel);
                end
                if (out_data.covered !== want.covered)
                begin
                    mismatches++;
                    $display("%0t covered: expected %b, actual %b",
                             $time, want.covered, out_data.covered);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rounded_rect_pixel_blender: mismatch");
            $finish;
        end
    end

    task automatic send_pixel(pix_in_t p, bit typed, pix_out_t typed_res);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_shades.push_back(typed ? typed_res : shade_pixel(p));
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_shades.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(rect_cfg_t c);
        settle();
        write_reg(REG_RECT_LEFT, c.left);
        write_reg(REG_RECT_TOP, c.top);
        write_reg(REG_RECT_WIDTH, c.width);
        write_reg(REG_RECT_HEIGHT, c.height);
        write_reg(REG_CORNER_RADIUS, c.radius);
        write_reg(REG_FILL_COLOR, c.fill);
        // spare indexes must not disturb anything
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
        regs_now = c;
    endtask

    initial
    begin
        int unsigned cur;
        pix_in_t     p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_RECT_LEFT;
        cfg_data = '0;
        regs_now = '{32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h0};

        directed_cfg[0] = '{32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h0};
        directed_cfg[1] = '{32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFF00FF00};
        directed_cfg[2] = '{32'd100, 32'd50, 32'd20, 32'd10, 32'd3, 32'h80FF0000};
        directed_cfg[3] = '{32'h7FF8, 32'hFFFB, 32'h7FFF, 32'h1, 32'd9, 32'h01ABCDEF};
        directed_cfg[4] = '{32'h0, 32'h0, 32'h8000, 32'd5, 32'h0, 32'hFFFFFFFF};
        directed_cfg[5] = '{32'h0, 32'h0, 32'd5, 32'hFFFF8000, 32'd2, 32'hFE102030};

        probes = '{
            '{0, 16'h0000, 16'h0000, 32'h12345678, 1'b1, 32'h12345678, 1'b1},
            '{0, 16'h0001, 16'h0000, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b0},
            '{0, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
            '{0, 16'h7FFF, 16'h7FFF, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
            '{0, 16'h8000, 16'h8000, 32'hDEADBEEF, 1'b1, 32'hDEADBEEF, 1'b0},
            '{1, 16'h8000, 16'h8000, 32'h00000000, 1'b0, 32'h0, 1'b0},
            '{1, 16'hC000, 16'hC000, 32'h11223344, 1'b1, 32'hFF00FF00, 1'b1},
            '{1, 16'hFFFE, 16'hFFFE, 32'h55667788, 1'b0, 32'h0, 1'b0},
            '{1, 16'hFFFF, 16'hC000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
            '{1, 16'h7FFF, 16'h0000, 32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F, 1'b0},
            '{2, 16'd100, 16'd50, 32'h00336699, 1'b0, 32'h0, 1'b0},
            '{2, 16'd100, 16'd52, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
            '{2, 16'd119, 16'd59, 32'h80808080, 1'b0, 32'h0, 1'b0},
            '{2, 16'd110, 16'd50, 32'h00000000, 1'b0, 32'h0, 1'b0},
            '{2, 16'd99, 16'd55, 32'h13579BDF, 1'b0, 32'h0, 1'b0},
            '{2, 16'd120, 16'd59, 32'h2468ACE0, 1'b0, 32'h0, 1'b0},
            '{3, 16'h7FFF, 16'hFFFB, 32'h00000000, 1'b0, 32'h0, 1'b0},
            '{3, 16'h7FF7, 16'hFFFB, 32'hFEDCBA98, 1'b0, 32'h0, 1'b0},
            '{3, 16'h7FFF, 16'hFFFC, 32'h76543210, 1'b0, 32'h0, 1'b0},
            '{4, 16'h0000, 16'h0000, 32'hC0FFEE00, 1'b1, 32'hC0FFEE00, 1'b0},
            '{4, 16'h8000, 16'h0000, 32'h00FFEE00, 1'b1, 32'h00FFEE00, 1'b0},
            '{5, 16'h0002, 16'h0000, 32'h89ABCDEF, 1'b1, 32'h89ABCDEF, 1'b0}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cur = 0;
        foreach (probes[i])
        begin
            if (probes[i].setting != cur)
            begin
                cur = probes[i].setting;
                apply_setting(directed_cfg[cur]);
            end
            p.pixel_x = probes[i].x;
            p.pixel_y = probes[i].y;
            p.dst_pixel = probes[i].dst;
            send_pixel(p, probes[i].typed, '{out_pixel: probes[i].pix, covered: probes[i].cov});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_setting(pick_setting(ph));
            steady = (ph == STEADY_PHASE);
            repeat (PHASE_ITEMS) send_pixel(pick_pixel(), 1'b0, '0);
            steady = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("rounded_rect_pixel_blender: match");
        else
            $display("rounded_rect_pixel_blender: mismatch");
        $finish;
    end

endmodule
